// ----- src/cbss_pkg.sv -----
// ----------------------------------------------------------------------------
// Cubic B-spline segment sampler package
// Shared constants, control-word types and the microcode program of the
// sampler sequencer.
// ----------------------------------------------------------------------------
package cbss_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int MAX_SAMPLES_DEF = 64;

  localparam int U_W        = 16;
  localparam int STEP_W     = 17;
  localparam int SPS_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int WSHIFT     = 24;
  localparam int W_W        = 28;
  localparam int PC_W       = 5;

  localparam logic [SPS_W-1:0]     SPS_RESET  = 7'd64;
  localparam logic [STEP_W-1:0]    STEP_RESET = 17'd1024;
  localparam logic [U_W-1:0]       U_MAX      = 16'hFFFF;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_STEP = 2'd1;

  localparam logic [PC_W-1:0] PC_START = 5'd0;

  typedef enum logic [1:0] {A_U, A_V, A_PROD, A_W} a_sel_e;
  typedef enum logic [1:0] {B_U, B_V, B_PX, B_PY} b_sel_e;
  typedef enum logic [3:0] {
    WB_NONE, WB_UU, WB_U3, WB_WGT, WB_ADDX, WB_ADDY, WB_PREP, WB_DIV
  } wb_e;
  typedef enum logic [1:0] {SQ_NEXT, SQ_EMIT} seq_e;

  typedef struct packed {
    a_sel_e          a_sel;
    b_sel_e          b_sel;
    logic [1:0]      idx;
    wb_e             wb;
    seq_e            seq;
    logic [PC_W-1:0] target;
  } uword_t;

  function automatic uword_t uop(input a_sel_e a, input b_sel_e b, input logic [1:0] i,
                                 input wb_e wb, input seq_e sq,
                                 input logic [PC_W-1:0] tg);
    uword_t w;
    w = '{a, b, i, wb, sq, tg};
    return w;
  endfunction

  // One sample: weights from u, then eight products into two accumulators,
  // then a divide by six by reciprocal multiplication and the output beat.
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      5'd0:    w = uop(A_U,    B_U,  2'd0, WB_NONE, SQ_NEXT, PC_START);
      5'd1:    w = uop(A_PROD, B_U,  2'd0, WB_UU,   SQ_NEXT, PC_START);
      5'd2:    w = uop(A_V,    B_V,  2'd0, WB_U3,   SQ_NEXT, PC_START);
      5'd3:    w = uop(A_PROD, B_V,  2'd0, WB_NONE, SQ_NEXT, PC_START);
      5'd4:    w = uop(A_U,    B_U,  2'd0, WB_WGT,  SQ_NEXT, PC_START);
      5'd5:    w = uop(A_W,    B_PX, 2'd0, WB_NONE, SQ_NEXT, PC_START);
      5'd6:    w = uop(A_W,    B_PY, 2'd0, WB_ADDX, SQ_NEXT, PC_START);
      5'd7:    w = uop(A_W,    B_PX, 2'd1, WB_ADDY, SQ_NEXT, PC_START);
      5'd8:    w = uop(A_W,    B_PY, 2'd1, WB_ADDX, SQ_NEXT, PC_START);
      5'd9:    w = uop(A_W,    B_PX, 2'd2, WB_ADDY, SQ_NEXT, PC_START);
      5'd10:   w = uop(A_W,    B_PY, 2'd2, WB_ADDX, SQ_NEXT, PC_START);
      5'd11:   w = uop(A_W,    B_PX, 2'd3, WB_ADDY, SQ_NEXT, PC_START);
      5'd12:   w = uop(A_W,    B_PY, 2'd3, WB_ADDX, SQ_NEXT, PC_START);
      5'd13:   w = uop(A_U,    B_U,  2'd0, WB_ADDY, SQ_NEXT, PC_START);
      5'd14:   w = uop(A_U,    B_U,  2'd0, WB_PREP, SQ_NEXT, PC_START);
      5'd15:   w = uop(A_U,    B_U,  2'd0, WB_DIV,  SQ_NEXT, PC_START);
      5'd16:   w = uop(A_U,    B_U,  2'd0, WB_NONE, SQ_EMIT, PC_START);
      default: w = uop(A_U,    B_U,  2'd0, WB_NONE, SQ_NEXT, PC_START);
    endcase
    return w;
  endfunction

endpackage

// ----- src/cubic_bspline_segment_sampler.sv -----
// ----------------------------------------------------------------------------
// Cubic B-spline segment sampler
// Keeps a window of three control points and, for each further point, emits
// a run of samples of the uniform cubic B-spline segment.
//
//   Channel  Dir  Handshake                  Payload
//   s_axis   in   s_axis_tvalid/tready       tdata: point_x, point_y; tuser: new_curve
//   m_axis   out  m_axis_tvalid/tready       tdata: curve_x, curve_y; tlast: last_of_segment
//   cfg      in   cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i
//
// A point that only fills the window is stored in it. A point that closes a
// segment runs the microcode once for each sample, stepping the single shared
// multiplier through weights and products, then one rounding step and one
// reciprocal multiply for the divide by six. The input is ready again in the
// cycle after the last sample is loaded. A stalled output beat holds the
// sequencer on its emit step. Reset empties the window and loads the register
// defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module cubic_bspline_segment_sampler
  import cbss_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  // tdata: point_x, point_y (low bits first), zero padded to bytes
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
  // tuser: new_curve
  input  logic                                     s_axis_tuser,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // tdata: curve_x, curve_y (low bits first), zero padded to bytes
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0]       m_axis_tdata,
  output logic                                     m_axis_tlast,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]                     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]                    cfg_data_i
);

  localparam int CW      = COORD_WIDTH;
  localparam int TDATA_W = ((2*CW+7)/8)*8;
  localparam int SAMP_W  = $clog2(MAX_SAMPLES+1);
  localparam int MA_W    = 34;
  localparam int MB_W    = (CW > 18) ? CW : 18;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int ACC_W   = CW + 30;
  localparam int T_W     = ACC_W - WSHIFT;
  localparam int NUM_W   = CW + 3;
  localparam int RP_W    = 2*CW + 5;

  localparam logic signed [ACC_W-1:0] ROUND  = ACC_W'(64'sd3 <<< WSHIFT);
  localparam logic signed [T_W-1:0]   LIM    = T_W'(64'sd3 <<< CW);
  localparam logic [NUM_W-1:0]        DIV6_M =
    NUM_W'(((64'd1 << (CW+5)) + 64'd5) / 64'd6);
  localparam logic [29:0]             W4    = 30'd4 << WSHIFT;
  localparam logic [29:0]             W1    = 30'd1 << WSHIFT;

  typedef enum logic {ST_IDLE, ST_RUN} state_e;

  typedef struct packed {
    logic             hi;
    logic             lo;
    logic [NUM_W-1:0] num;
    logic [CW-1:0]    quo;
  } div_t;

  function automatic div_t div_prep(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] s;
    logic signed [T_W-1:0]   t;
    logic [T_W-1:0]          n;
    div_t                    d;
    s     = acc + ROUND;
    t     = signed'(s[ACC_W-1:WSHIFT]);
    n     = unsigned'(t + LIM);
    d.hi  = (t >= LIM);
    d.lo  = (t < -LIM);
    d.num = n[NUM_W-1:0];
    d.quo = '0;
    return d;
  endfunction

  function automatic div_t div_step(input div_t d);
    logic [RP_W-1:0] p;
    div_t            r;
    p     = RP_W'(d.num) * RP_W'(DIV6_M);
    r     = d;
    r.quo = p[RP_W-1:CW+5];
    return r;
  endfunction

  function automatic logic [CW-1:0] div_result(input div_t d);
    logic [CW-1:0] v;
    if (d.hi) begin
      v = {1'b0, {(CW-1){1'b1}}};
    end else if (d.lo) begin
      v = {1'b1, {(CW-1){1'b0}}};
    end else begin
      v = {~d.quo[CW-1], d.quo[CW-2:0]};
    end
    return v;
  endfunction

  state_e                  state_q, state_d;
  logic [PC_W-1:0]         pc_q, pc_d;
  logic [SPS_W-1:0]        sps_q, sps_d;
  logic [STEP_W-1:0]       step_q, step_d;
  logic signed [CW-1:0]    win_x_q [3];
  logic signed [CW-1:0]    win_x_d [3];
  logic signed [CW-1:0]    win_y_q [3];
  logic signed [CW-1:0]    win_y_d [3];
  logic [1:0]              held_q, held_d;
  logic [SAMP_W-1:0]       n_q, n_d, k_q, k_d;
  logic [U_W-1:0]          u_q, u_d;
  logic                    out_valid_q, out_valid_d;
  logic                    out_last_q, out_last_d;
  logic [CW-1:0]           out_x_q, out_x_d, out_y_q, out_y_d;

  logic signed [CW-1:0]    pt_x_q, pt_x_d, pt_y_q, pt_y_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic [31:0]             uu_q, uu_d;
  logic [23:0]             u3_q, u3_d;
  logic signed [W_W-1:0]   w_q [4];
  logic signed [W_W-1:0]   w_d [4];
  logic signed [ACC_W-1:0] accx_q, accx_d, accy_q, accy_d;
  div_t                    divx_q, divx_d, divy_q, divy_d;

  uword_t                  uw;
  logic [STEP_W-1:0]       v_val;
  logic signed [CW-1:0]    px_sel, py_sel;
  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic [29:0]             u3e, u2e, ue8, w1_val, w2_val;
  logic [U_W+1:0]          u_sum;
  logic                    out_free;
  logic                    last_smp;
  logic [1:0]              held_eff;
  logic signed [CW-1:0]    in_x, in_y;

  assign uw            = ucode(pc_q);
  assign v_val         = {1'b1, {U_W{1'b0}}} - {1'b0, u_q};
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = TDATA_W'({out_y_q, out_x_q});
  assign in_x          = signed'(s_axis_tdata[CW-1:0]);
  assign in_y          = signed'(s_axis_tdata[2*CW-1:CW]);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign last_smp      = (SAMP_W'(k_q + 1'b1) == n_q);
  assign held_eff      = s_axis_tuser ? 2'd0 : held_q;

  assign u3e    = 30'(u3_q);
  assign u2e    = 30'(uu_q[31:8]);
  assign ue8    = 30'({u_q, 8'h00});
  assign w1_val = 30'd3 * u3e - 30'd6 * u2e + W4;
  assign w2_val = 30'd3 * u2e + 30'd3 * ue8 + W1 - 30'd3 * u3e;
  assign u_sum  = {2'b00, u_q} + {1'b0, step_q};

  always_comb begin
    case (uw.idx)
      2'd0:    begin px_sel = win_x_q[0]; py_sel = win_y_q[0]; end
      2'd1:    begin px_sel = win_x_q[1]; py_sel = win_y_q[1]; end
      2'd2:    begin px_sel = win_x_q[2]; py_sel = win_y_q[2]; end
      default: begin px_sel = pt_x_q;     py_sel = pt_y_q;     end
    endcase
  end

  always_comb begin
    case (uw.a_sel)
      A_U:     mul_a = signed'(MA_W'(u_q));
      A_V:     mul_a = signed'(MA_W'(v_val));
      A_PROD:  mul_a = signed'(MA_W'(prod_q[32:0]));
      A_W:     mul_a = MA_W'(w_q[uw.idx]);
      default: mul_a = '0;
    endcase
    case (uw.b_sel)
      B_U:     mul_b = signed'(MB_W'(u_q));
      B_V:     mul_b = signed'(MB_W'(v_val));
      B_PX:    mul_b = MB_W'(px_sel);
      B_PY:    mul_b = MB_W'(py_sel);
      default: mul_b = '0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    sps_d       = sps_q;
    step_d      = step_q;
    win_x_d     = win_x_q;
    win_y_d     = win_y_q;
    held_d      = held_q;
    n_d         = n_q;
    k_d         = k_q;
    u_d         = u_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_last_d  = out_last_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    pt_x_d      = pt_x_q;
    pt_y_d      = pt_y_q;
    prod_d      = PROD_W'(mul_a) * PROD_W'(mul_b);
    uu_d        = uu_q;
    u3_d        = u3_q;
    w_d         = w_q;
    accx_d      = accx_q;
    accy_d      = accy_q;
    divx_d      = divx_q;
    divy_d      = divy_q;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_IDX_SPS:  sps_d = cfg_data_i[SPS_W-1:0];
        CFG_IDX_STEP: step_d = cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser) begin
            win_x_d = '{default: '0};
            win_y_d = '{default: '0};
          end
          if (held_eff != 2'd3) begin
            for (int i = 0; i < 3; i++) begin
              if (held_eff == 2'(i)) begin
                win_x_d[i] = in_x;
                win_y_d[i] = in_y;
              end
            end
            held_d = held_eff + 2'd1;
          end else begin
            pt_x_d  = in_x;
            pt_y_d  = in_y;
            k_d     = '0;
            u_d     = '0;
            pc_d    = PC_START;
            state_d = ST_RUN;
            if (sps_q == '0) begin
              n_d = SAMP_W'(1);
            end else if (32'(sps_q) > MAX_SAMPLES) begin
              n_d = SAMP_W'(MAX_SAMPLES);
            end else begin
              n_d = SAMP_W'(sps_q);
            end
          end
        end
      end
      ST_RUN: begin
        case (uw.wb)
          WB_UU: uu_d = prod_q[31:0];
          WB_U3: u3_d = prod_q[47:24];
          WB_WGT: begin
            w_d[0] = W_W'(prod_q[48:24]);
            w_d[1] = signed'(w1_val[W_W-1:0]);
            w_d[2] = signed'(w2_val[W_W-1:0]);
            w_d[3] = W_W'(u3_q);
            accx_d = '0;
            accy_d = '0;
          end
          WB_ADDX: accx_d = accx_q + ACC_W'(prod_q);
          WB_ADDY: accy_d = accy_q + ACC_W'(prod_q);
          WB_PREP: begin
            divx_d = div_prep(accx_q);
            divy_d = div_prep(accy_q);
          end
          WB_DIV: begin
            divx_d = div_step(divx_q);
            divy_d = div_step(divy_q);
          end
          default: ;
        endcase

        case (uw.seq)
          SQ_NEXT: pc_d = pc_q + 1'b1;
          SQ_EMIT: begin
            if (out_free) begin
              out_valid_d = 1'b1;
              out_last_d  = last_smp;
              out_x_d     = div_result(divx_q);
              out_y_d     = div_result(divy_q);
              if (last_smp) begin
                state_d    = ST_IDLE;
                win_x_d[0] = win_x_q[1];
                win_x_d[1] = win_x_q[2];
                win_x_d[2] = pt_x_q;
                win_y_d[0] = win_y_q[1];
                win_y_d[1] = win_y_q[2];
                win_y_d[2] = pt_y_q;
              end else begin
                k_d  = k_q + 1'b1;
                u_d  = (u_sum > {2'b00, U_MAX}) ? U_MAX : u_sum[U_W-1:0];
                pc_d = uw.target;
              end
            end
          end
          default: pc_d = pc_q + 1'b1;
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= PC_START;
      sps_q       <= SPS_RESET;
      step_q      <= STEP_RESET;
      win_x_q     <= '{default: '0};
      win_y_q     <= '{default: '0};
      held_q      <= '0;
      n_q         <= '0;
      k_q         <= '0;
      u_q         <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      sps_q       <= sps_d;
      step_q      <= step_d;
      win_x_q     <= win_x_d;
      win_y_q     <= win_y_d;
      held_q      <= held_d;
      n_q         <= n_d;
      k_q         <= k_d;
      u_q         <= u_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
      out_x_q     <= out_x_d;
      out_y_q     <= out_y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pt_x_q <= pt_x_d;
    pt_y_q <= pt_y_d;
    prod_q <= prod_d;
    uu_q   <= uu_d;
    u3_q   <= u3_d;
    w_q    <= w_d;
    accx_q <= accx_d;
    accy_q <= accy_d;
    divx_q <= divx_d;
    divy_q <= divy_d;
  end

endmodule

// ----- tb/cubic_bspline_segment_sampler_test.sv -----
// ----------------------------------------------------------------------------
// Cubic B-spline segment sampler testbench
// Streams control points into the sampler and checks every curve sample
// against a fixed-point predictor of the uniform cubic B-spline. A directed
// table covers the register extremes and the window fill, slide and restart.
// Random phases of well-formed curves with random content follow, under
// bursty input and a patterned output stall.
// ----------------------------------------------------------------------------
module cubic_bspline_segment_sampler_test;
  import cbss_pkg::*;

  localparam int CW            = COORD_WIDTH_DEF;
  localparam int TDATA_W       = ((2*CW+7)/8)*8;
  localparam int SAMPLE_CYCLES = 17;
  localparam int SETTLE_CYCLES = 2*SAMPLE_CYCLES;
  localparam int CLK_PERIOD    = 8;
  localparam int LIMIT_CYCLES  = 3_000_000;
  localparam int RANDOM_ITEMS  = 150;
  localparam int MAX_SHOWN     = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE0 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE1 = 2'd3;

  typedef logic signed [CW-1:0] coord_t;
  typedef longint weight_set_t [4];

  localparam coord_t C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } sample_t;

  typedef enum logic {ROW_POINT, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e                kind;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_DATA_W-1:0]    data;
    coord_t                   x;
    coord_t                   y;
    logic                     nc;
    logic                     typed;
    coord_t                   tx;
    coord_t                   ty;
  } stim_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_SKIP_FOURTH, RX_COIN, RX_TRICKLE} rx_pattern_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic [TDATA_W-1:0]    s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [TDATA_W-1:0]    m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  cubic_bspline_segment_sampler u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #(CLK_PERIOD/2) clk_i = 1'b1;
    #(CLK_PERIOD/2) clk_i = 1'b0;
  end

  // Spline state mirrored from the block.
  logic [SPS_W-1:0]  model_sps = SPS_RESET;
  logic [STEP_W-1:0] model_step = STEP_RESET;
  coord_t            win_x [3];
  coord_t            win_y [3];
  int unsigned       held = 0;

  sample_t     pending_samples [$];
  int unsigned error_count = 0;
  int unsigned samples_checked = 0;
  int unsigned points_sent = 0;
  int unsigned random_points = 0;
  int unsigned reg_writes = 0;
  int unsigned burst_left = 0;

  function automatic weight_set_t spline_weights(input longint unsigned u);
    weight_set_t     w;
    longint unsigned v;
    longint          u2, u3, v3, one;
    one  = longint'(1) << WSHIFT;
    v    = 65536 - u;
    u2   = longint'((u*u) >> 8);
    u3   = longint'((u*u*u) >> WSHIFT);
    v3   = longint'((v*v*v) >> WSHIFT);
    w[0] = v3;
    w[1] = 3*u3 - 6*u2 + 4*one;
    w[2] = -3*u3 + 3*u2 + 3*longint'(u << 8) + one;
    w[3] = u3;
    return w;
  endfunction

  function automatic coord_t blend_coord(input coord_t p0, input coord_t p1, input coord_t p2,
                                         input coord_t p3, input weight_set_t w);
    longint acc, den, q, hi, lo;
    den = 6*(longint'(1) << WSHIFT);
    hi  = (longint'(1) << (CW-1)) - 1;
    lo  = -hi - 1;
    acc = w[0]*longint'(p0) + w[1]*longint'(p1) + w[2]*longint'(p2) + w[3]*longint'(p3);
    acc = acc + 3*(longint'(1) << WSHIFT);
    if (acc >= 0) begin
      q = acc / den;
    end else begin
      q = -((-acc + den - 1) / den);
    end
    if (q > hi) q = hi;
    if (q < lo) q = lo;
    return coord_t'(q);
  endfunction

  task automatic predict_point(input coord_t px, input coord_t py, input logic nc,
                               input logic typed, input coord_t tx, input coord_t ty);
    int unsigned     n;
    longint unsigned u;
    weight_set_t     w;
    sample_t         s;
    if (nc) begin
      held = 0;
      for (int i = 0; i < 3; i++) begin
        win_x[i] = '0;
        win_y[i] = '0;
      end
    end
    if (held < 3) begin
      win_x[held] = px;
      win_y[held] = py;
      held++;
      return;
    end
    n = model_sps;
    if (n < 1) n = 1;
    if (n > MAX_SAMPLES_DEF) n = MAX_SAMPLES_DEF;
    for (int unsigned k = 0; k < n; k++) begin
      u = longint'(k) * longint'(model_step);
      if (u > U_MAX) u = U_MAX;
      w = spline_weights(u);
      s.x = blend_coord(win_x[0], win_x[1], win_x[2], px, w);
      s.y = blend_coord(win_y[0], win_y[1], win_y[2], py, w);
      if (typed && k == 0) begin
        s.x = tx;
        s.y = ty;
      end
      s.last = (k == n-1);
      pending_samples.push_back(s);
    end
    win_x[0] = win_x[1];
    win_x[1] = win_x[2];
    win_x[2] = px;
    win_y[0] = win_y[1];
    win_y[1] = win_y[2];
    win_y[2] = py;
  endtask

  task automatic send_point(input coord_t px, input coord_t py, input logic nc,
                            input logic typed, input coord_t tx, input coord_t ty);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 45) : $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    s_axis_tdata  <= TDATA_W'({py, px});
    s_axis_tuser  <= nc;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    points_sent++;
    predict_point(px, py, nc, typed, tx, ty);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_IDX_SPS: begin
        model_sps = data[SPS_W-1:0];
      end
      CFG_IDX_STEP: begin
        model_step = data[STEP_W-1:0];
      end
      default: begin
      end
    endcase
    reg_writes++;
  endtask

  // Lets the sampler drain; a point that only fills the window leaves nothing
  // to wait for, so the given number of extra cycles pass as well.
  task automatic settle(input int unsigned extra);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  function automatic coord_t random_coord();
    case ($urandom_range(0, 9))
      0:       return C_MAX;
      1:       return C_MIN;
      2:       return '0;
      3:       return '1;
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic random_phase();
    int unsigned           n_eff, items;
    logic [SPS_W-1:0]      sps_val;
    logic [CFG_DATA_W-1:0] sps_word, step_word;
    logic                  nc;
    settle(SETTLE_CYCLES);
    case ($urandom_range(0, 19))
      0:       sps_val = '0;
      1:       sps_val = SPS_W'(MAX_SAMPLES_DEF);
      2:       sps_val = SPS_W'($urandom_range(MAX_SAMPLES_DEF+1, (1 << SPS_W)-1));
      3:       sps_val = SPS_W'($urandom_range(9, MAX_SAMPLES_DEF-1));
      default: sps_val = SPS_W'($urandom_range(1, 8));
    endcase
    n_eff = (sps_val == 0) ? 1 : (sps_val > MAX_SAMPLES_DEF) ? MAX_SAMPLES_DEF : sps_val;
    sps_word = CFG_DATA_W'($urandom);
    if ($urandom_range(0, 1)) sps_word[CFG_DATA_W-1:SPS_W] = '0;
    sps_word[SPS_W-1:0] = sps_val;
    case ($urandom_range(0, 9))
      0:       step_word = '0;
      1:       step_word = CFG_DATA_W'(1);
      2:       step_word = CFG_DATA_W'(65535);
      3:       step_word = CFG_DATA_W'(65536);
      4:       step_word = '1;
      5:       step_word = CFG_DATA_W'($urandom);
      default: step_word = CFG_DATA_W'($urandom_range(1, 65536 / n_eff));
    endcase
    if ($urandom_range(0, 3) == 0) begin
      write_reg($urandom_range(0, 1) ? CFG_IDX_SPARE0 : CFG_IDX_SPARE1,
                CFG_DATA_W'($urandom));
    end
    write_reg(CFG_IDX_SPS, sps_word);
    write_reg(CFG_IDX_STEP, step_word);
    cfg_valid_i <= 1'b0;
    items = (n_eff > 16) ? $urandom_range(3, 5) : $urandom_range(5, 14);
    for (int unsigned i = 0; i < items; i++) begin
      nc = (i == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 11) == 0);
      send_point(random_coord(), random_coord(), nc, 1'b0, '0, '0);
    end
    random_points += items;
  endtask

  function automatic stim_row_t pt(input coord_t x, input coord_t y, input logic nc);
    stim_row_t r;
    r = '{ROW_POINT, CFG_IDX_SPS, '0, x, y, nc, 1'b0, '0, '0};
    return r;
  endfunction

  function automatic stim_row_t pt_typed(input coord_t x, input coord_t y, input logic nc,
                                         input coord_t tx, input coord_t ty);
    stim_row_t r;
    r = '{ROW_POINT, CFG_IDX_SPS, '0, x, y, nc, 1'b1, tx, ty};
    return r;
  endfunction

  function automatic stim_row_t wr(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r = '{ROW_REG, idx, data, '0, '0, 1'b0, 1'b0, '0, '0};
    return r;
  endfunction

  always @(posedge clk_i) begin
    sample_t want;
    sample_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.x    = coord_t'(m_axis_tdata[CW-1:0]);
      got.y    = coord_t'(m_axis_tdata[2*CW-1:CW]);
      got.last = m_axis_tlast;
      samples_checked++;
      if (pending_samples.size() == 0) begin
        error_count++;
        if (error_count <= MAX_SHOWN) begin
          $display("unexpected beat: x=%0d y=%0d last=%0d", got.x, got.y, got.last);
        end
      end else begin
        want = pending_samples.pop_front();
        if (got !== want) begin
          error_count++;
          if (error_count <= MAX_SHOWN) begin
            $display("beat %0d: expected x=%0d y=%0d last=%0d, got x=%0d y=%0d last=%0d",
                     samples_checked, want.x, want.y, want.last, got.x, got.y, got.last);
          end
        end
      end
    end
  end

  rx_pattern_e rx_pattern = RX_OPEN;
  int unsigned rx_cycle = 0;

  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 300 == 299) rx_pattern <= rx_pattern_e'($urandom_range(0, 3));
    case (rx_pattern)
      RX_OPEN:        m_axis_tready <= 1'b1;
      RX_SKIP_FOURTH: m_axis_tready <= (rx_cycle % 4) != 3;
      RX_COIN:        m_axis_tready <= 1'($urandom_range(0, 1));
      default:        m_axis_tready <= (rx_cycle % 16) < 5;
    endcase
  end

  initial begin
    #(LIMIT_CYCLES*CLK_PERIOD);
    $display("cubic_bspline_segment_sampler_test: errors");
    $finish;
  end

  initial begin
    stim_row_t directed_rows [$];
    logic      reg_group;
    reg_group = 1'b0;
    directed_rows = '{
      pt(C_MAX, C_MAX, 1'b1),
      pt(C_MAX, C_MAX, 1'b0),
      pt(C_MAX, C_MAX, 1'b0),
      pt_typed(C_MAX, C_MAX, 1'b0, C_MAX, C_MAX),
      pt(C_MIN, C_MIN, 1'b1),
      pt(C_MIN, C_MIN, 1'b0),
      pt(C_MIN, C_MIN, 1'b0),
      pt_typed(C_MIN, C_MIN, 1'b0, C_MIN, C_MIN),
      wr(CFG_IDX_SPS, CFG_DATA_W'(1)),
      wr(CFG_IDX_STEP, '0),
      pt(C_MAX, C_MIN, 1'b0),
      pt(C_MIN, C_MAX, 1'b0),
      pt(coord_t'(12345), coord_t'(-2222), 1'b0),
      wr(CFG_IDX_SPS, '0),
      pt(coord_t'(1), coord_t'(-1), 1'b0),
      wr(CFG_IDX_SPS, CFG_DATA_W'(2)),
      wr(CFG_IDX_STEP, '1),
      pt(coord_t'(-1), coord_t'(1), 1'b0),
      pt(C_MAX, C_MAX, 1'b0),
      wr(CFG_IDX_SPARE0, '1),
      wr(CFG_IDX_SPARE1, CFG_DATA_W'(85)),
      wr(CFG_IDX_SPS, CFG_DATA_W'(127)),
      wr(CFG_IDX_STEP, CFG_DATA_W'(1)),
      pt('0, '0, 1'b1),
      pt(C_MIN, C_MAX, 1'b0),
      pt(C_MAX, C_MIN, 1'b0),
      pt(coord_t'(-20000), coord_t'(30000), 1'b0),
      wr(CFG_IDX_SPS, CFG_DATA_W'('h1FF85)),
      wr(CFG_IDX_STEP, CFG_DATA_W'(65536)),
      pt(C_MIN, C_MIN, 1'b0),
      pt(coord_t'(7), C_MAX, 1'b0)
    };
    for (int i = 0; i < 3; i++) begin
      win_x[i] = '0;
      win_y[i] = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        if (!reg_group) settle(SETTLE_CYCLES);
        reg_group = 1'b1;
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        if (reg_group) cfg_valid_i <= 1'b0;
        reg_group = 1'b0;
        send_point(directed_rows[i].x, directed_rows[i].y, directed_rows[i].nc,
                   directed_rows[i].typed, directed_rows[i].tx, directed_rows[i].ty);
      end
    end

    while (random_points < RANDOM_ITEMS) random_phase();

    settle(4*SAMPLE_CYCLES);
    $display("Streamed %0d control points (%0d in random curves) and checked %0d samples.",
             points_sent, random_points, samples_checked);
    $display("Register writes: %0d, sample counts from zero to the cap, steps up to past one.",
             reg_writes);
    if (error_count == 0 && pending_samples.size() == 0) begin
      $display("cubic_bspline_segment_sampler_test: clean");
    end else begin
      $display("cubic_bspline_segment_sampler_test: errors");
    end
    $finish;
  end

endmodule
